### rtl/core/pfn_pkg.sv
package pfn_pkg;

  localparam int MAX_OCTAVES = 8;
  localparam int FRAC_BITS   = 16;
  localparam int OCT_W       = $clog2(MAX_OCTAVES);
  localparam int OCTCNT_W    = 4;
  localparam int MODE_W      = 2;
  localparam int COORD_W     = 32;
  localparam int FREQ_W      = 24;
  localparam int OUT_W       = 20;
  localparam int CELL_W      = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = FREQ_W;

  // coord (16 fraction bits) times frequency (16 fraction bits)
  localparam int PT_FRAC = 32;
  localparam int PT_W    = PT_FRAC + CELL_W;

  localparam int FX_ONE = 1 << FRAC_BITS;
  localparam int CRD_W  = FRAC_BITS + 2;
  localparam int GRD_W  = FRAC_BITS + 4;
  localparam int LX_W   = FRAC_BITS + 5;
  localparam int TERM_W = FRAC_BITS + 6;
  localparam int ACC_W  = TERM_W + MAX_OCTAVES + 1;

  // normalization: N = 2|acc| + tot, q = floor(N / (2 tot)) by reciprocal
  localparam int NUM_W     = FRAC_BITS + MAX_OCTAVES + 3;
  localparam int RCP_W     = 30;
  localparam int RECIP_SH  = 37;
  localparam int Q_W       = NUM_W + RCP_W - RECIP_SH;
  localparam int TOT_W     = MAX_OCTAVES + 1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  localparam int OUT_MAX = (1 << (OUT_W - 1)) - 1;
  localparam int OUT_MIN = -(1 << (OUT_W - 1));

  localparam logic [MODE_W-1:0] MODE_FBM    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BILLOW = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RIDGED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OCT  = 2'd2;

  typedef struct packed {
    logic [PT_W-1:0] px;
    logic [PT_W-1:0] py;
  } point_t;

  typedef struct packed {
    logic             last;
    logic [OCT_W-1:0] oct;
  } oct_tag_t;

  // ceil(2^RECIP_SH / (2 * tot)) for k = index + 1 octaves
  localparam logic [RCP_W-1:0] RECIP [MAX_OCTAVES] = '{
    30'd536870912, 30'd357913942, 30'd306783379, 30'd286331154,
    30'd277094665, 30'd272696337, 30'd270549122, 30'd269488145
  };

  localparam logic [7:0] PERM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
    8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,
    8'd8,8'd99,8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,
    8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,
    8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,
    8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,
    8'd134,8'd139,8'd48,8'd27,8'd166,8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,
    8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
    8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,8'd65,8'd25,8'd63,8'd161,
    8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,
    8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,8'd164,
    8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,
    8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,
    8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,
    8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,
    8'd44,8'd154,8'd163,8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,
    8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,
    8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,8'd97,
    8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,
    8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,
    8'd107,8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,
    8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,
    8'd138,8'd236,8'd205,8'd93,8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,
    8'd141,8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
  };

  // amplitude total for kidx + 1 octaves: 2^M - 2^(M-1-kidx)
  function automatic logic [TOT_W-1:0] tot_f(input logic [OCT_W-1:0] kidx);
    return TOT_W'((1 << MAX_OCTAVES) - (1 << (MAX_OCTAVES - 1 - int'(kidx))));
  endfunction

  // 8-direction gradient: +-u +- 2v
  function automatic logic signed [GRD_W-1:0] grad_f(
    input logic [2:0] h, input logic signed [CRD_W-1:0] x, input logic signed [CRD_W-1:0] y);
    logic signed [GRD_W-1:0] u;
    logic signed [GRD_W-1:0] v;
    logic signed [GRD_W-1:0] r;
    u = h[2] ? GRD_W'(y) : GRD_W'(x);
    v = h[2] ? GRD_W'(x) : GRD_W'(y);
    r = h[0] ? -u : u;
    return r + (h[1] ? -(v <<< 1) : (v <<< 1));
  endfunction

  // a + floor((b - a) * f / 2^F)
  function automatic logic signed [LX_W-1:0] lerp_f(
    input logic [FRAC_BITS:0] f, input logic signed [LX_W-1:0] a,
    input logic signed [LX_W-1:0] b);
    logic signed [LX_W:0]             d;
    logic signed [LX_W+FRAC_BITS+2:0] p;
    d = (LX_W+1)'(b) - (LX_W+1)'(a);
    p = d * $signed({1'b0, f});
    return a + LX_W'(p >>> FRAC_BITS);
  endfunction

endpackage

### rtl/core/pfn_front.sv
module pfn_front import pfn_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      take,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  input  logic [FREQ_W-1:0]         freq,
  output logic                      push,
  output point_t                    pt
);

  logic                      cap_vld_r;
  logic signed [COORD_W-1:0] cx_r;
  logic signed [COORD_W-1:0] cy_r;
  logic signed [COORD_W+FREQ_W:0] prod_x;
  logic signed [COORD_W+FREQ_W:0] prod_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_vld_r <= 1'b0;
    end else begin
      cap_vld_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cx_r <= coord_x;
      cy_r <= coord_y;
    end
  end

  // scaled point, only the low PT_W bits matter (lattice wraps at 256)
  assign prod_x = cx_r * $signed({1'b0, freq});
  assign prod_y = cy_r * $signed({1'b0, freq});
  assign push   = cap_vld_r;
  assign pt.px  = prod_x[PT_W-1:0];
  assign pt.py  = prod_y[PT_W-1:0];

endmodule

### rtl/core/pfn_queue.sv
module pfn_queue import pfn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  point_t            wdata,
  input  logic              pop,
  output logic              valid,
  output point_t            rdata,
  output logic [QCNT_W-1:0] count
);

  point_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic [QCNT_W-1:0]   cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + QCNT_W'(1);
    if (!push && pop) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  assign valid = (cnt_r != '0);
  assign rdata = mem_r[rd_ptr_r];
  assign count = cnt_r;

endmodule

### rtl/core/pfn_octave.sv
module pfn_octave import pfn_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     i_vld,
  input  oct_tag_t                 i_tag,
  input  logic [CELL_W-1:0]        i_cx,
  input  logic [CELL_W-1:0]        i_cy,
  input  logic [FRAC_BITS-1:0]     i_fx,
  input  logic [FRAC_BITS-1:0]     i_fy,
  input  logic [MODE_W-1:0]        i_mode,
  output logic                     o_vld,
  output oct_tag_t                 o_tag,
  output logic signed [TERM_W-1:0] o_term
);

  localparam int NSTG = 7;
  localparam int F    = FRAC_BITS;
  localparam logic signed [F+4:0]   FIFTEEN_FX = (F+5)'(15 * FX_ONE);
  localparam logic signed [F+4:0]   TEN_FX     = (F+5)'(10 * FX_ONE);
  localparam logic signed [CRD_W-1:0] ONE_C    = CRD_W'(FX_ONE);
  localparam logic signed [TERM_W-1:0] ONE_T   = TERM_W'(FX_ONE);

  logic [NSTG-1:0] vld_r;
  oct_tag_t        tag_r [NSTG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NSTG-2:0], i_vld};
    end
  end

  always_ff @(posedge clk) begin
    tag_r[0] <= i_tag;
    for (int s = 1; s < NSTG; s++) tag_r[s] <= tag_r[s-1];
  end

  // stage 1: t^2, (6t-15)t, first permutation lookup
  logic [F-1:0]        t_in [2];
  logic [2*F-1:0]      sq [2];
  logic [F+2:0]        six [2];
  logic signed [F+4:0] lin [2];
  logic signed [2*F+5:0] bprod [2];

  logic [F-1:0]        s1_t_r  [2];
  logic [F-1:0]        s1_t2_r [2];
  logic signed [F+4:0] s1_bq_r [2];
  logic [7:0]          s1_pa_r;
  logic [7:0]          s1_pb_r;
  logic [7:0]          s1_cy_r;

  assign t_in[0] = i_fx;
  assign t_in[1] = i_fy;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      sq[a]    = t_in[a] * t_in[a];
      six[a]   = {1'b0, t_in[a], 2'b00} + {2'b00, t_in[a], 1'b0};
      lin[a]   = $signed({2'b00, six[a]}) - FIFTEEN_FX;
      bprod[a] = lin[a] * $signed({1'b0, t_in[a]});
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 2; a++) begin
      s1_t_r[a]  <= t_in[a];
      s1_t2_r[a] <= sq[a][2*F-1:F];
      s1_bq_r[a] <= $signed(bprod[a][2*F+4:F]);
    end
    s1_pa_r <= PERM[i_cx];
    s1_pb_r <= PERM[i_cx + 8'd1];
    s1_cy_r <= i_cy;
  end

  // stage 2: t^3, fade polynomial tail, corner hashes
  logic [2*F-1:0]      cub [2];
  logic signed [F+4:0] bps [2];
  logic [7:0]          ha;
  logic [7:0]          hb;

  logic [F-1:0]   s2_t_r  [2];
  logic [F-1:0]   s2_t3_r [2];
  logic [F+3:0]   s2_bp_r [2];
  logic [7:0]     s2_h_r  [4];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      cub[a] = s1_t2_r[a] * s1_t_r[a];
      bps[a] = s1_bq_r[a] + TEN_FX;
    end
    ha = s1_pa_r + s1_cy_r;
    hb = s1_pb_r + s1_cy_r;
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 2; a++) begin
      s2_t_r[a]  <= s1_t_r[a];
      s2_t3_r[a] <= cub[a][2*F-1:F];
      s2_bp_r[a] <= bps[a][F+3:0];
    end
    s2_h_r[0] <= PERM[ha];
    s2_h_r[1] <= PERM[hb];
    s2_h_r[2] <= PERM[ha + 8'd1];
    s2_h_r[3] <= PERM[hb + 8'd1];
  end

  // stage 3: fade value, gradient selectors
  logic [2*F+3:0] fprod [2];
  logic [F-1:0]   s3_t_r  [2];
  logic [F:0]     s3_fd_r [2];
  logic [2:0]     s3_g_r  [4];

  always_comb begin
    for (int a = 0; a < 2; a++) fprod[a] = s2_t3_r[a] * s2_bp_r[a];
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 2; a++) begin
      s3_t_r[a]  <= s2_t_r[a];
      s3_fd_r[a] <= fprod[a][2*F:F];
    end
    for (int c = 0; c < 4; c++) s3_g_r[c] <= PERM[s2_h_r[c]][2:0];
  end

  // stage 4: corner gradients
  logic signed [CRD_W-1:0] gx;
  logic signed [CRD_W-1:0] gy;
  logic signed [GRD_W-1:0] s4_g_r  [4];
  logic [F:0]              s4_fd_r [2];

  assign gx = $signed({2'b00, s3_t_r[0]});
  assign gy = $signed({2'b00, s3_t_r[1]});

  always_ff @(posedge clk) begin
    s4_g_r[0] <= grad_f(s3_g_r[0], gx,         gy);
    s4_g_r[1] <= grad_f(s3_g_r[1], gx - ONE_C, gy);
    s4_g_r[2] <= grad_f(s3_g_r[2], gx,         gy - ONE_C);
    s4_g_r[3] <= grad_f(s3_g_r[3], gx - ONE_C, gy - ONE_C);
    s4_fd_r   <= s3_fd_r;
  end

  // stage 5: lerp along x
  logic signed [LX_W-1:0] s5_l_r [2];
  logic [F:0]             s5_v_r;

  always_ff @(posedge clk) begin
    s5_l_r[0] <= lerp_f(s4_fd_r[0], LX_W'(s4_g_r[0]), LX_W'(s4_g_r[1]));
    s5_l_r[1] <= lerp_f(s4_fd_r[0], LX_W'(s4_g_r[2]), LX_W'(s4_g_r[3]));
    s5_v_r    <= s4_fd_r[1];
  end

  // stage 6: lerp along y
  logic signed [LX_W-1:0] s6_n_r;

  always_ff @(posedge clk) begin
    s6_n_r <= lerp_f(s5_v_r, s5_l_r[0], s5_l_r[1]);
  end

  // stage 7: per-mode octave term
  logic signed [TERM_W-1:0]   n_ext;
  logic signed [TERM_W-1:0]   n_abs;
  logic signed [TERM_W-1:0]   rg;
  logic signed [2*TERM_W-1:0] rg_sq;
  logic signed [TERM_W-1:0]   term;

  always_comb begin
    n_ext = TERM_W'(s6_n_r);
    n_abs = (n_ext < 0) ? -n_ext : n_ext;
    rg    = ONE_T - n_abs;
    rg_sq = rg * rg;
    case (i_mode)
      MODE_RIDGED: term = $signed(rg_sq[TERM_W+F-1:F]);
      MODE_BILLOW: term = n_abs;
      default:     term = n_ext;
    endcase
  end

  always_ff @(posedge clk) begin
    o_term <= term;
  end

  assign o_vld = vld_r[NSTG-1];
  assign o_tag = tag_r[NSTG-1];

endmodule

### rtl/core/pfn_back.sv
module pfn_back import pfn_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  input  point_t                  q_data,
  output logic                    q_pop,
  input  logic [MODE_W-1:0]       mode,
  input  logic [OCTCNT_W-1:0]     octave_count,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_value
);

  localparam int F = FRAC_BITS;
  localparam int SH_DN = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SH_UP = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(OUT_MAX);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(OUT_MIN);
  localparam logic [F:0] ONE_W = (F+1)'(FX_ONE);

  // octave sequencer: one octave of the head item issued per cycle
  logic [OCT_W-1:0] oct_cnt_r;
  logic [OCT_W-1:0] last_oct;
  logic [PT_W-1:0]  sx;
  logic [PT_W-1:0]  sy;
  oct_tag_t         iss_tag;

  always_comb begin
    if (octave_count == '0) begin
      last_oct = '0;
    end else if (octave_count > OCTCNT_W'(MAX_OCTAVES)) begin
      last_oct = OCT_W'(MAX_OCTAVES - 1);
    end else begin
      last_oct = OCT_W'(octave_count - OCTCNT_W'(1));
    end
  end

  assign q_pop        = q_valid && (oct_cnt_r == last_oct);
  assign iss_tag.last = (oct_cnt_r == last_oct);
  assign iss_tag.oct  = oct_cnt_r;
  assign sx = q_data.px << oct_cnt_r;
  assign sy = q_data.py << oct_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oct_cnt_r <= '0;
    end else if (q_pop) begin
      oct_cnt_r <= '0;
    end else if (q_valid) begin
      oct_cnt_r <= oct_cnt_r + OCT_W'(1);
    end
  end

  logic                     o_vld;
  oct_tag_t                 o_tag;
  logic signed [TERM_W-1:0] o_term;

  pfn_octave u_octave (
    .clk    (clk),
    .rst_n  (rst_n),
    .i_vld  (q_valid),
    .i_tag  (iss_tag),
    .i_cx   (sx[PT_W-1 -: CELL_W]),
    .i_cy   (sy[PT_W-1 -: CELL_W]),
    .i_fx   (sx[PT_FRAC-1 -: FRAC_BITS]),
    .i_fy   (sy[PT_FRAC-1 -: FRAC_BITS]),
    .i_mode (mode),
    .o_vld  (o_vld),
    .o_tag  (o_tag),
    .o_term (o_term)
  );

  // accumulate, ridged weight feedback
  logic                       ridged;
  logic [F:0]                 w_r;
  logic [F:0]                 w_cur;
  logic [F:0]                 w_nxt;
  logic signed [TERM_W+F+1:0] sg_prod;
  logic signed [TERM_W-1:0]   sg;
  logic signed [TERM_W-1:0]   sel;
  logic signed [ACC_W-1:0]    add;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [ACC_W-1:0]    acc_nxt;
  logic                       done_r;
  logic [OCT_W-1:0]           done_k_r;

  assign ridged = (mode == MODE_RIDGED);

  always_comb begin
    w_cur   = (o_tag.oct == '0) ? ONE_W : w_r;
    sg_prod = o_term * $signed({1'b0, w_cur});
    sg      = $signed(sg_prod[TERM_W+F-1:F]);
    if (sg >= TERM_W'(FX_ONE / 2)) begin
      w_nxt = ONE_W;
    end else begin
      w_nxt = {1'b0, sg[F-2:0], 1'b0};
    end
    sel     = ridged ? sg : o_term;
    add     = ACC_W'(sel) <<< (MAX_OCTAVES - 1 - int'(o_tag.oct));
    acc_nxt = ((o_tag.oct == '0) ? ACC_W'(0) : acc_r) + add;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= o_vld && o_tag.last;
    end
  end

  always_ff @(posedge clk) begin
    if (o_vld) begin
      acc_r    <= acc_nxt;
      w_r      <= w_nxt;
      done_k_r <= o_tag.oct;
    end
  end

  // normalize: rounded division by the amplitude total, or in ridged mode a right shift
  logic                    d1_vld_r;
  logic                    d1_neg_r;
  logic [NUM_W-1:0]        d1_num_r;
  logic [OCT_W-1:0]        d1_k_r;
  logic signed [ACC_W-1:0] d1_rdg_r;
  logic [ACC_W-1:0]        mag;

  assign mag = (acc_r < 0) ? ACC_W'(-acc_r) : ACC_W'(acc_r);

  always_ff @(posedge clk) begin
    d1_neg_r <= acc_r < 0;
    d1_num_r <= NUM_W'({mag, 1'b0}) + NUM_W'(tot_f(done_k_r));
    d1_k_r   <= done_k_r;
    d1_rdg_r <= acc_r >>> (MAX_OCTAVES - 1);
  end

  logic                      d2_vld_r;
  logic                      d2_neg_r;
  logic [NUM_W+RCP_W-1:0]    qprod;
  logic [Q_W-1:0]            d2_q_r;
  logic signed [ACC_W-1:0]   d2_rdg_r;

  assign qprod = d1_num_r * RECIP[d1_k_r];

  always_ff @(posedge clk) begin
    d2_neg_r <= d1_neg_r;
    d2_q_r   <= qprod[NUM_W+RCP_W-1:RECIP_SH];
    d2_rdg_r <= d1_rdg_r;
  end

  logic signed [ACC_W-1:0] q_s;
  logic signed [ACC_W-1:0] res;
  logic signed [ACC_W-1:0] res_q;

  always_comb begin
    q_s   = $signed(ACC_W'(d2_q_r));
    res   = ridged ? d2_rdg_r : (d2_neg_r ? -q_s : q_s);
    res_q = (res >>> SH_DN) <<< SH_UP;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_vld_r  <= 1'b0;
      d2_vld_r  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      d1_vld_r  <= done_r;
      d2_vld_r  <= d1_vld_r;
      out_valid <= d2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (res_q > SAT_HI) begin
      out_value <= OUT_W'(SAT_HI);
    end else if (res_q < SAT_LO) begin
      out_value <= OUT_W'(SAT_LO);
    end else begin
      out_value <= OUT_W'(res_q);
    end
  end

endmodule

### rtl/core/perlin_fractal_noise_2d_core.sv
// Fractal 2D gradient noise core (fBm, billow, ridged).
// Input: pulse start with in_coord_x/in_coord_y (signed Q16.16); the beat is
// taken when start is high and busy is low. busy rises when the 4-deep input
// queue and the capture stage together hold 4 beats.
// Output: out_valid strobes for one cycle with out_noise_value (signed Q3.16,
// saturated). The receiver cannot stall; every result is shown exactly once.
// Config: cfg_we/cfg_index/cfg_wdata write noise_mode (0), base_frequency (1)
// and octave_count (2); other indexes are ignored. Write only while idle.
// An accepted beat passes the capture register, input queue, octave sequencer,
// noise pipeline, accumulator and normalize registers. K = octave_count
// clamped to 1..8 is the octave count per beat. The octave sequencer issues
// one octave per cycle into the shared 7-stage noise pipeline, so K sets the
// rate. Beats queue up while earlier ones are still in the pipeline.
// Reset (rst_n low, synchronous): queue and pipeline empty, noise_mode 0,
// base_frequency 1.0, octave_count 4.
module perlin_fractal_noise_2d_core import pfn_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_y,
  output logic                      out_valid,
  output logic signed [OUT_W-1:0]   out_noise_value,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata
);

  // configuration registers
  logic [MODE_W-1:0]   mode_r;
  logic [FREQ_W-1:0]   freq_r;
  logic [OCTCNT_W-1:0] octs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_FBM;
      freq_r <= FREQ_W'(FX_ONE);
      octs_r <= OCTCNT_W'(4);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE: mode_r <= cfg_wdata[MODE_W-1:0];
        CFG_FREQ: freq_r <= cfg_wdata[FREQ_W-1:0];
        CFG_OCT:  octs_r <= cfg_wdata[OCTCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // front: capture the beat and scale the point
  logic              take;
  logic              f_push;
  point_t            f_pt;
  logic              q_valid;
  logic              q_pop;
  point_t            q_data;
  logic [QCNT_W-1:0] q_count;
  logic [QCNT_W:0]   occ;

  assign take = start && !busy;
  // conservative: the captured beat always lands in the queue next cycle
  assign occ  = {1'b0, q_count} + {{QCNT_W{1'b0}}, f_push};
  assign busy = (occ >= (QCNT_W+1)'(QDEPTH));

  pfn_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .coord_x (in_coord_x),
    .coord_y (in_coord_y),
    .freq    (freq_r),
    .push    (f_push),
    .pt      (f_pt)
  );

  pfn_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata (f_pt),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_data),
    .count (q_count)
  );

  // back: octave issue, noise pipeline, accumulate, normalize
  pfn_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .mode         (mode_r),
    .octave_count (octs_r),
    .out_valid    (out_valid),
    .out_value    (out_noise_value)
  );

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    f_push |-> (q_count != QCNT_W'(QDEPTH)) || q_pop)
    else $error("beat pushed into a full queue");

  a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_take_reaches_queue: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> f_push)
    else $error("accepted beat not forwarded to the queue");

endmodule
